// ----- design/htw_pkg.sv -----
package htw_pkg;

  localparam int NearBits  = 8;
  localparam int FarBits   = 6;
  localparam int LinkW     = 6;
  localparam int HeadAddrW = 9;
  localparam int HeadDepth = 512;
  localparam int RemW      = 17;

  localparam logic [LinkW-1:0] NilLink = 6'd63;

  typedef enum logic [1:0] {
    FUNC_ADD,
    FUNC_REMOVE,
    FUNC_TICK,
    FUNC_NONE
  } func_e;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_REMOVE,
    KIND_FIRED,
    KIND_TICK
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_REM_RD,
    ST_REM_CMP,
    ST_WALK_RD,
    ST_WALK_HEAD,
    ST_WALK_CHK,
    ST_WALK_REC,
    ST_PUSH_RD,
    ST_PUSH_WR,
    ST_ADVANCE,
    ST_CAS_RD,
    ST_CAS_HEAD,
    ST_CAS_CHK,
    ST_CAS_REC
  } state_e;

  typedef enum logic [1:0] {
    RET_ADD,
    RET_WALK,
    RET_CAS
  } ret_e;

  typedef struct packed {
    logic [LinkW-1:0]       link;
    logic [31:0]            expire;
    logic [31:0]            period;
    logic signed [RemW-1:0] remain;
    logic [31:0]            owner;
  } pool_rec_t;

  typedef struct packed {
    logic [HeadAddrW-1:0] arm_addr;
    logic [31:0]          arm_expire;
    logic [HeadAddrW-1:0] move_addr;
  } place_t;

endpackage

// ----- design/hierarchical_timer_wheel_core.sv -----
// Hierarchical timing wheel over a pool of MAX_TIMERS timers. Issue a request with start
// while busy is low; func selects add, remove or tick. Every result appears on kind_o,
// result_id_o and last_o for exactly one cycle with result_valid_o high and cannot be
// stalled, so the receiver must take it on that cycle. All list heads live in one
// 512-entry memory and all timer records in one MAX_TIMERS-entry memory, each with a
// registered read port; the request rate follows from those single ports. An add links
// the new timer in front of its slot list; a remove scans the pool entries in order up
// to the first live match or the last entry; a tick walks the current near slot, firing
// each live timer and re-arming or freeing it, and on every 256th tick cascades the far
// wheels, moving timers down. After reset all 512 head entries are cleared with busy high.
module hierarchical_timer_wheel_core import htw_pkg::*; #(
  parameter int MAX_TIMERS = 32,
  parameter int FAR_WHEELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [31:0] interval_ticks_i,
  input  logic signed [15:0] repeat_count_i,
  input  logic [31:0] timer_id_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [31:0] result_id_o,
  output logic        last_o
);

  localparam int PW   = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int RecW = $bits(pool_rec_t);

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;

  logic [31:0]           tick_q, tick_d;
  logic [31:0]           last_id_q, last_id_d;
  logic [MAX_TIMERS-1:0] in_use_q, in_use_d;
  logic [31:0]           ival_q, ival_d;
  logic signed [15:0]    rep_q, rep_d;
  logic [31:0]           tid_q, tid_d;
  logic [LinkW-1:0]      cur_q, cur_d;
  logic [LinkW-1:0]      nxt_q, nxt_d;
  logic [PW-1:0]         scan_q, scan_d;
  logic [1:0]            lvl_q, lvl_d;
  logic [HeadAddrW-1:0]  clr_q, clr_d;
  logic [HeadAddrW-1:0]  tgt_q, tgt_d;
  pool_rec_t             rec_q, rec_d;

  logic        out_vld_q, out_vld_d;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] id_q, id_d;
  logic        last_q, last_d;

  // memory ports
  logic                 head_we;
  logic [HeadAddrW-1:0] head_waddr, head_raddr;
  logic [LinkW-1:0]     head_wdata, head_rdata;
  logic                 pool_we;
  logic [PW-1:0]        pool_waddr, pool_raddr;
  pool_rec_t            pool_wdata, pool_rdata;
  logic [RecW-1:0]      pool_rdata_raw;

  // placement
  logic [31:0] place_period;
  place_t      place;

  // decoded conditions
  logic                 accept;
  logic                 free_found;
  logic [PW-1:0]        free_idx;
  logic                 add_ok;
  logic [31:0]          new_id;
  logic                 cur_nil;
  logic [PW-1:0]        cur_idx;
  logic                 walk_live;
  logic                 walk_forever;
  logic signed [RemW-1:0] walk_dec;
  logic                 walk_rearm;
  logic [31:0]          tick_inc;
  logic [FarBits-1:0]   cas_idx;
  logic                 cas_stop;
  logic                 rem_hit;
  logic                 scan_last;
  logic [HeadAddrW-1:0] near_slot;
  logic [HeadAddrW-1:0] cas_addr;

  htw_ram #(.WIDTH(LinkW), .DEPTH(HeadDepth)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  htw_ram #(.WIDTH(RecW), .DEPTH(MAX_TIMERS)) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (pool_we),
    .waddr_i (pool_waddr),
    .wdata_i (pool_wdata),
    .raddr_i (pool_raddr),
    .rdata_o (pool_rdata_raw)
  );

  assign pool_rdata = pool_rec_t'(pool_rdata_raw);

  htw_place #(.FAR_WHEELS(FAR_WHEELS)) u_place (
    .tick_i   (tick_q),
    .period_i (place_period),
    .expire_i (pool_rdata.expire),
    .level_i  (lvl_q),
    .place_o  (place)
  );

  assign place_period = (state_q == ST_ADD) ? ival_q : pool_rdata.period;

  // find the lowest free pool entry
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = PW'(i);
      end
    end
  end

  assign accept       = start && !busy;
  assign add_ok       = free_found && rep_q != 16'sd0 &&
                        (rep_q == 16'sd1 || ival_q != 32'd0);
  assign new_id       = (last_id_q == 32'hFFFF_FFFF) ? 32'd1 : last_id_q + 32'd1;
  assign cur_nil      = cur_q >= LinkW'(MAX_TIMERS);
  assign cur_idx      = cur_q[PW-1:0];
  assign walk_live    = pool_rdata.remain != '0;
  assign walk_forever = pool_rdata.remain == -17'sd1;
  assign walk_dec     = pool_rdata.remain - 17'sd1;
  assign walk_rearm   = walk_live && (walk_forever || walk_dec > 17'sd0);
  assign tick_inc     = tick_q + 32'd1;
  assign near_slot    = {1'b0, tick_q[NearBits-1:0]};
  assign rem_hit      = in_use_q[scan_q] && pool_rdata.remain != '0 &&
                        pool_rdata.owner == tid_q;
  assign scan_last    = scan_q == PW'(MAX_TIMERS - 1);

  // slot of the far wheel that the cascade visits
  always_comb begin
    case (lvl_q)
      2'd0:    cas_idx = tick_q[NearBits +: FarBits];
      2'd1:    cas_idx = tick_q[NearBits + FarBits +: FarBits];
      2'd2:    cas_idx = tick_q[NearBits + 2 * FarBits +: FarBits];
      default: cas_idx = tick_q[NearBits + 3 * FarBits +: FarBits];
    endcase
  end

  assign cas_addr = {1'b1, lvl_q, cas_idx};
  assign cas_stop = cas_idx != '0 || lvl_q == 2'(FAR_WHEELS - 1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == HeadAddrW'(HeadDepth - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (func_e'(func_i))
            FUNC_ADD:    state_d = ST_ADD;
            FUNC_REMOVE: state_d = ST_REM_RD;
            FUNC_TICK:   state_d = ST_WALK_RD;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD:       state_d = add_ok ? ST_PUSH_RD : ST_IDLE;
      ST_REM_RD:    state_d = (tid_q == 32'd0) ? ST_IDLE : ST_REM_CMP;
      ST_REM_CMP:   state_d = (rem_hit || scan_last) ? ST_IDLE : ST_REM_RD;
      ST_WALK_RD:   state_d = ST_WALK_HEAD;
      ST_WALK_HEAD: state_d = ST_WALK_CHK;
      ST_WALK_CHK:  state_d = cur_nil ? ST_ADVANCE : ST_WALK_REC;
      ST_WALK_REC:  state_d = walk_rearm ? ST_PUSH_RD : ST_WALK_CHK;
      ST_PUSH_RD:   state_d = ST_PUSH_WR;
      ST_PUSH_WR: begin
        case (ret_q)
          RET_ADD:  state_d = ST_IDLE;
          RET_WALK: state_d = ST_WALK_CHK;
          default:  state_d = ST_CAS_CHK;
        endcase
      end
      ST_ADVANCE: begin
        state_d = (tick_inc[NearBits-1:0] != '0) ? ST_IDLE : ST_CAS_RD;
      end
      ST_CAS_RD:    state_d = ST_CAS_HEAD;
      ST_CAS_HEAD:  state_d = ST_CAS_CHK;
      ST_CAS_CHK: begin
        if (!cur_nil) begin
          state_d = ST_CAS_REC;
        end else if (cas_stop) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_CAS_RD;
        end
      end
      ST_CAS_REC:   state_d = ST_PUSH_RD;
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath, memory ports and results
  always_comb begin
    ret_d      = ret_q;
    tick_d     = tick_q;
    last_id_d  = last_id_q;
    in_use_d   = in_use_q;
    ival_d     = ival_q;
    rep_d      = rep_q;
    tid_d      = tid_q;
    cur_d      = cur_q;
    nxt_d      = nxt_q;
    scan_d     = scan_q;
    lvl_d      = lvl_q;
    clr_d      = clr_q;
    tgt_d      = tgt_q;
    rec_d      = rec_q;
    out_vld_d  = 1'b0;
    kind_d     = kind_q;
    id_d       = id_q;
    last_d     = last_q;
    head_we    = 1'b0;
    head_waddr = near_slot;
    head_wdata = NilLink;
    head_raddr = near_slot;
    pool_we    = 1'b0;
    pool_waddr = cur_idx;
    pool_wdata = rec_q;
    pool_raddr = cur_idx;

    case (state_q)
      ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
        clr_d      = clr_q + HeadAddrW'(1);
      end
      ST_IDLE: begin
        // latch the request
        if (accept) begin
          ival_d = interval_ticks_i;
          rep_d  = repeat_count_i;
          tid_d  = timer_id_i;
          scan_d = '0;
        end
      end
      ST_ADD: begin
        if (add_ok) begin
          last_id_d          = new_id;
          in_use_d[free_idx] = 1'b1;
          cur_d              = LinkW'(free_idx);
          rec_d.owner        = new_id;
          rec_d.period       = ival_q;
          rec_d.remain       = RemW'(rep_q);
          rec_d.expire       = place.arm_expire;
          tgt_d              = place.arm_addr;
          ret_d              = RET_ADD;
        end else begin
          out_vld_d = 1'b1;
          kind_d    = KIND_ADD;
          id_d      = 32'd0;
          last_d    = 1'b1;
        end
      end
      ST_REM_RD: begin
        pool_raddr = scan_q;
        if (tid_q == 32'd0) begin
          out_vld_d = 1'b1;
          kind_d    = KIND_REMOVE;
          id_d      = 32'd0;
          last_d    = 1'b1;
        end
      end
      ST_REM_CMP: begin
        // cancel the first live match
        if (rem_hit) begin
          pool_we           = 1'b1;
          pool_waddr        = scan_q;
          pool_wdata        = pool_rdata;
          pool_wdata.remain = '0;
        end
        if (rem_hit || scan_last) begin
          out_vld_d = 1'b1;
          kind_d    = KIND_REMOVE;
          id_d      = 32'd0;
          last_d    = 1'b1;
        end else begin
          scan_d = scan_q + PW'(1);
        end
      end
      ST_WALK_RD: begin
        head_raddr = near_slot;
      end
      ST_WALK_HEAD: begin
        // take the slot list and empty the slot
        cur_d      = head_rdata;
        head_we    = 1'b1;
        head_waddr = near_slot;
      end
      ST_WALK_CHK: begin
        pool_raddr = cur_idx;
      end
      ST_WALK_REC: begin
        nxt_d = pool_rdata.link;
        if (walk_live) begin
          out_vld_d = 1'b1;
          kind_d    = KIND_FIRED;
          id_d      = pool_rdata.owner;
          last_d    = 1'b0;
        end
        if (walk_rearm) begin
          rec_d        = pool_rdata;
          rec_d.remain = walk_forever ? pool_rdata.remain : walk_dec;
          rec_d.expire = place.arm_expire;
          tgt_d        = place.arm_addr;
          ret_d        = RET_WALK;
        end else begin
          in_use_d[cur_idx] = 1'b0;
          cur_d             = pool_rdata.link;
        end
      end
      ST_PUSH_RD: begin
        head_raddr = tgt_q;
      end
      ST_PUSH_WR: begin
        // link the timer in front of the slot list
        head_we         = 1'b1;
        head_waddr      = tgt_q;
        head_wdata      = cur_q;
        pool_we         = 1'b1;
        pool_waddr      = cur_idx;
        pool_wdata      = rec_q;
        pool_wdata.link = head_rdata;
        if (ret_q == RET_ADD) begin
          out_vld_d = 1'b1;
          kind_d    = KIND_ADD;
          id_d      = rec_q.owner;
          last_d    = 1'b1;
        end else begin
          cur_d = nxt_q;
        end
      end
      ST_ADVANCE: begin
        tick_d = tick_inc;
        lvl_d  = '0;
        if (tick_inc[NearBits-1:0] != '0) begin
          out_vld_d = 1'b1;
          kind_d    = KIND_TICK;
          id_d      = 32'd0;
          last_d    = 1'b1;
        end
      end
      ST_CAS_RD: begin
        head_raddr = cas_addr;
      end
      ST_CAS_HEAD: begin
        cur_d      = head_rdata;
        head_we    = 1'b1;
        head_waddr = cas_addr;
      end
      ST_CAS_CHK: begin
        pool_raddr = cur_idx;
        if (cur_nil) begin
          if (cas_stop) begin
            out_vld_d = 1'b1;
            kind_d    = KIND_TICK;
            id_d      = 32'd0;
            last_d    = 1'b1;
          end else begin
            lvl_d = lvl_q + 2'd1;
          end
        end
      end
      ST_CAS_REC: begin
        // move the timer down one or more wheels
        nxt_d = pool_rdata.link;
        rec_d = pool_rdata;
        tgt_d = place.move_addr;
        ret_d = RET_CAS;
      end
      default: begin
        ret_d = ret_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      ret_q     <= RET_ADD;
      tick_q    <= '0;
      last_id_q <= '0;
      in_use_q  <= '0;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      tick_q    <= tick_d;
      last_id_q <= last_id_d;
      in_use_q  <= in_use_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ival_q <= ival_d;
    rep_q  <= rep_d;
    tid_q  <= tid_d;
    cur_q  <= cur_d;
    nxt_q  <= nxt_d;
    scan_q <= scan_d;
    lvl_q  <= lvl_d;
    tgt_q  <= tgt_d;
    rec_q  <= rec_d;
    kind_q <= kind_d;
    id_q   <= id_d;
    last_q <= last_d;
  end

  assign busy           = state_q != ST_IDLE;
  assign result_valid_o = out_vld_q;
  assign kind_o         = kind_q;
  assign result_id_o    = id_q;
  assign last_o         = last_q;

endmodule

// ----- design/htw_ram.sv -----
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- design/htw_place.sv -----
module htw_place import htw_pkg::*; #(
  parameter int FAR_WHEELS = 4
) (
  input  logic [31:0]  tick_i,
  input  logic [31:0]  period_i,
  input  logic [31:0]  expire_i,
  input  logic [1:0]   level_i,
  output place_t       place_o
);

  logic [31:0]          arm_exp;
  logic [HeadAddrW-1:0] arm_addr;
  logic [HeadAddrW-1:0] move_addr;
  logic                 arm_found;
  logic                 move_found;

  // pick the wheel and slot for a fresh arm
  always_comb begin
    arm_exp   = tick_i + period_i;
    arm_addr  = {1'b0, arm_exp[NearBits-1:0]};
    arm_found = 1'b0;
    if (period_i[31:NearBits] != '0) begin
      for (int i = 0; i < 4; i++) begin
        if (i < FAR_WHEELS && !arm_found) begin
          if ((period_i >> (NearBits + FarBits * (i + 1))) == 32'd0 ||
              i == FAR_WHEELS - 1) begin
            arm_addr  = {1'b1, 2'(i), arm_exp[NearBits + FarBits * i +: FarBits]};
            arm_found = 1'b1;
          end
        end
      end
    end
  end

  // find the lower wheel a cascaded timer drops into
  always_comb begin
    move_addr  = {1'b0, expire_i[NearBits-1:0]};
    move_found = 1'b0;
    for (int l = 3; l >= 1; l--) begin
      if (l <= int'(level_i) && !move_found) begin
        if (expire_i[NearBits + FarBits * (l - 1) +: FarBits] != '0) begin
          move_addr  = {1'b1, 2'(l - 1), expire_i[NearBits + FarBits * (l - 1) +: FarBits]};
          move_found = 1'b1;
        end
      end
    end
  end

  assign place_o = '{arm_addr: arm_addr, arm_expire: arm_exp, move_addr: move_addr};

endmodule

// ----- design/htw_checker.sv -----
module htw_checker import htw_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  func_i,
  input logic        result_valid_o,
  input logic [1:0]  kind_o,
  input logic [31:0] result_id_o,
  input logic        last_o
);

  // an add reply always closes its request
  a_add_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == KIND_ADD |-> last_o)
    else $error("add reply without last");

  // a fired timer is never the closing result
  a_fired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == KIND_FIRED |-> !last_o)
    else $error("fired result marked last");

  // remove and tick completions carry no id
  a_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o == KIND_REMOVE || kind_o == KIND_TICK) |-> result_id_o == 32'd0)
    else $error("completion with nonzero id");

  // a valid request keeps the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && func_i != FUNC_NONE |=> busy)
    else $error("request accepted without busy");

  // nothing follows the closing result in the next cycle
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o)
    else $error("result right after last");

endmodule

bind hierarchical_timer_wheel_core htw_checker u_htw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .func_i         (func_i),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .result_id_o    (result_id_o),
  .last_o         (last_o)
);

// ----- tb/sv/hierarchical_timer_wheel_core_tb.sv -----
`timescale 1ns / 1ps

module hierarchical_timer_wheel_core_tb;
  import htw_pkg::*;

  localparam int PoolSize   = 32;
  localparam int NearSlots  = 256;
  localparam int FarSlots   = 64;
  localparam int Wheels     = 4;
  localparam int CycleLimit = 400000;

  typedef struct {
    kind_e       kind;
    logic [31:0] id;
    logic        last;
  } reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  func_i;
  logic [31:0] interval_ticks_i;
  logic signed [15:0] repeat_count_i;
  logic [31:0] timer_id_i;
  logic        result_valid_o;
  logic [1:0]  kind_o;
  logic [31:0] result_id_o;
  logic        last_o;

  hierarchical_timer_wheel_core #(
    .MAX_TIMERS(PoolSize),
    .FAR_WHEELS(Wheels)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .func_i(func_i),
    .interval_ticks_i(interval_ticks_i),
    .repeat_count_i(repeat_count_i),
    .timer_id_i(timer_id_i),
    .result_valid_o(result_valid_o),
    .kind_o(kind_o),
    .result_id_o(result_id_o),
    .last_o(last_o)
  );

  // Wheel state as the block should hold it
  logic [31:0] now_tick;
  logic [31:0] id_counter;
  logic [5:0]  near_list [NearSlots];
  logic [5:0]  far_list  [Wheels*FarSlots];
  logic [5:0]  link_of   [PoolSize];
  logic [31:0] due_tick  [PoolSize];
  logic [31:0] period_of [PoolSize];
  int          shots_left[PoolSize];
  logic [31:0] id_of     [PoolSize];
  bit          busy_slot [PoolSize];

  reply_t      pending_replies[$];
  logic [31:0] issued_ids[$];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet;

  // Clock and cycle limit
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic void push_near(int t, logic [31:0] idx);
    link_of[t] = near_list[idx[7:0]];
    near_list[idx[7:0]] = 6'(t);
  endfunction

  function automatic void push_far(int t, int wheel, logic [31:0] idx);
    int h;
    h = (wheel % 4) * FarSlots + int'(idx[5:0]);
    link_of[t] = far_list[h];
    far_list[h] = 6'(t);
  endfunction

  function automatic void arm_timer(int t);
    logic [31:0] iv;
    logic [31:0] idx;
    iv = period_of[t];
    idx = now_tick + iv;
    due_tick[t] = idx;
    if (iv < NearSlots) begin
      push_near(t, idx);
      return;
    end
    iv = iv >> 8;
    idx = idx >> 8;
    for (int i = 0; i < Wheels; i++) begin
      if (iv < FarSlots || i == Wheels - 1) begin
        push_far(t, i, idx);
        return;
      end
      iv = iv >> 6;
      idx = idx >> 6;
    end
  endfunction

  function automatic void move_down(int t, int level);
    logic [31:0] idx;
    while (level > 0) begin
      idx = (due_tick[t] >> ((level - 1) * 6 + 8)) & 32'd63;
      if (idx != 0) begin
        push_far(t, level - 1, idx);
        return;
      end
      level--;
    end
    push_near(t, due_tick[t]);
  endfunction

  // Move far-list timers down to lower wheels when the near wheel wraps
  function automatic void cascade_wheels();
    logic [31:0] ft;
    logic [31:0] idx;
    int h;
    int t;
    int nx;
    if (now_tick[7:0] != 0) return;
    ft = now_tick >> 8;
    for (int i = 0; i < Wheels; i++) begin
      idx = ft & 32'd63;
      h = i * FarSlots + int'(idx);
      t = far_list[h];
      far_list[h] = NilLink;
      while (t < PoolSize) begin
        nx = link_of[t];
        move_down(t, i);
        t = nx;
      end
      if (idx != 0) break;
      ft = ft >> 6;
    end
  endfunction

  function automatic void queue_reply(kind_e k, logic [31:0] id);
    reply_t r;
    r.kind = k;
    r.id = id;
    r.last = 1'b0;
    pending_replies.push_back(r);
  endfunction

  // Work out the results of one accepted request
  function automatic void predict_request(logic [1:0] fn, logic [31:0] iv,
                                          logic signed [15:0] rc, logic [31:0] id);
    int times;
    int t;
    int nx;
    logic [31:0] newid;
    times = int'(rc);
    newid = '0;
    case (fn)
      FUNC_ADD: begin
        if (times != 0 && (times == 1 || iv >= 1)) begin
          for (t = 0; t < PoolSize; t++) if (!busy_slot[t]) break;
          if (t < PoolSize) begin
            id_counter = id_counter + 1;
            if (id_counter == 0) id_counter = 1;
            newid = id_counter;
            busy_slot[t] = 1'b1;
            id_of[t] = newid;
            period_of[t] = iv;
            shots_left[t] = times;
            arm_timer(t);
            issued_ids.push_back(newid);
          end
        end
        queue_reply(KIND_ADD, newid);
      end
      FUNC_REMOVE: begin
        if (id != 0) begin
          for (t = 0; t < PoolSize; t++) begin
            if (busy_slot[t] && shots_left[t] != 0 && id_of[t] == id) begin
              shots_left[t] = 0;
              break;
            end
          end
        end
        queue_reply(KIND_REMOVE, '0);
      end
      FUNC_TICK: begin
        t = near_list[now_tick[7:0]];
        near_list[now_tick[7:0]] = NilLink;
        while (t < PoolSize) begin
          nx = link_of[t];
          if (shots_left[t] != 0) begin
            queue_reply(KIND_FIRED, id_of[t]);
            if (shots_left[t] == -1) begin
              arm_timer(t);
            end else begin
              shots_left[t]--;
              if (shots_left[t] > 0) arm_timer(t);
              else begin
                shots_left[t] = 0;
                busy_slot[t] = 1'b0;
              end
            end
          end else begin
            busy_slot[t] = 1'b0;
          end
          t = nx;
        end
        now_tick = now_tick + 1;
        cascade_wheels();
        queue_reply(KIND_TICK, '0);
      end
      default: return;
    endcase
    pending_replies[$].last = 1'b1;
  endfunction

  // Compare every result with the oldest expectation
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected result", result_id_o, '0);
      end else begin
        want = pending_replies.pop_front();
        if (kind_o != want.kind) report_mismatch("kind", kind_o, want.kind);
        if (result_id_o != want.id) report_mismatch("result_id", result_id_o, want.id);
        if (last_o != want.last) report_mismatch("last", last_o, want.last);
      end
    end
  end

  // Hold the request until the block takes it; start stays high for the next one unless a random gap drops it
  task automatic send_request(logic [1:0] fn, logic [31:0] iv, logic signed [15:0] rc,
                              logic [31:0] id);
    start <= 1'b1;
    func_i <= fn;
    interval_ticks_i <= iv;
    repeat_count_i <= rc;
    timer_id_i <= id;
    do @(posedge clk_i); while (busy);
    predict_request(fn, iv, rc, id);
    if (!quiet && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic test_add_cases();
    send_request(FUNC_ADD, 32'd0, 16'sd1, '0);
    send_request(FUNC_ADD, 32'd0, 16'sd2, '0);
    send_request(FUNC_ADD, 32'd7, 16'sd0, '0);
    send_request(FUNC_ADD, 32'hFFFF_FFFF, 16'sd1, '0);
    send_request(FUNC_ADD, 32'd5, -16'sd1, '0);
    send_request(FUNC_ADD, 32'd3, -16'sd7, '0);
    send_request(FUNC_ADD, 32'd2, 16'sh7FFF, '0);
    send_request(FUNC_NONE, 32'hFFFF_FFFF, -16'sd1, 32'hFFFF_FFFF);
  endtask

  task automatic test_remove_cases();
    send_request(FUNC_REMOVE, '0, '0, 32'd0);
    send_request(FUNC_REMOVE, '0, '0, 32'hFFFF_FFFF);
    send_request(FUNC_REMOVE, '0, '0, 32'd2);
    send_request(FUNC_REMOVE, '0, '0, 32'd3);
    send_request(FUNC_REMOVE, '0, '0, 32'd3);
    repeat (8) send_request(FUNC_TICK, '0, '0, '0);
  endtask

  task automatic test_pool_full();
    repeat (PoolSize + 2) send_request(FUNC_ADD, 32'd1, 16'sd1, '0);
    repeat (3) send_request(FUNC_TICK, '0, '0, '0);
  endtask

  task automatic test_random_traffic();
    logic [31:0] iv;
    logic signed [15:0] rc;
    logic [31:0] id;
    int pick;
    for (int n = 0; n < 350; n++) begin
      quiet = (n >= 150 && n < 230);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: iv = $urandom_range(0, 12);
          11, 12, 13, 14, 15:               iv = $urandom_range(13, 255);
          16, 17:                           iv = $urandom_range(256, 700);
          default:                          iv = $urandom;
        endcase
        case ($urandom_range(0, 19))
          0, 1, 2, 3:             rc = -16'sd1;
          4, 5, 6, 7, 8, 9:       rc = 16'sd1;
          10, 11, 12, 13, 14, 15: rc = 16'($urandom_range(2, 4));
          16:                     rc = 16'sd0;
          17:                     rc = -16'($urandom_range(2, 32768));
          default:                rc = 16'($urandom);
        endcase
        send_request(FUNC_ADD, iv, rc, $urandom);
      end else if (pick < 48) begin
        case ($urandom_range(0, 9))
          0:       id = $urandom;
          1:       id = 32'd0;
          default: id = issued_ids.size() ? issued_ids[$urandom_range(0, issued_ids.size()-1)]
                                           : 32'd1;
        endcase
        send_request(FUNC_REMOVE, $urandom, 16'($urandom), id);
      end else if (pick < 98) begin
        send_request(FUNC_TICK, $urandom, 16'($urandom), $urandom);
      end else begin
        send_request(FUNC_NONE, $urandom, 16'($urandom), $urandom);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    func_i = FUNC_NONE;
    interval_ticks_i = '0;
    repeat_count_i = '0;
    timer_id_i = '0;
    quiet = 1'b0;
    now_tick = '0;
    id_counter = '0;
    foreach (near_list[i]) near_list[i] = NilLink;
    foreach (far_list[i]) far_list[i] = NilLink;
    foreach (busy_slot[i]) busy_slot[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_add_cases();
    test_remove_cases();
    test_pool_full();
    test_random_traffic();

    // Drain and let the block settle
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
